// ===== rtl/core/sctl_pkg.sv =====
`timescale 1ns / 1ps

package sctl_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int ID_W            = 8;
    localparam int KEY_W           = 8;
    localparam int TOTAL_W         = 5;

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_ROTATE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_FULL         = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND    = 2'd2;
    localparam logic [1:0] ST_EMPTY_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]              func;
        logic [ID_W-1:0]         entry_id;
        logic signed [KEY_W-1:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]         head_id;
        logic signed [KEY_W-1:0] head_priority;
        logic                    list_empty;
        logic [TOTAL_W-1:0]      entry_total;
        logic [1:0]              status;
    } out_item_t;

    // broadcast to every cell
    typedef struct packed {
        logic                    enable;
        logic [1:0]              func;
        logic [ID_W-1:0]         entry_id;
        logic signed [KEY_W-1:0] priority_req;
    } cell_cmd_t;

    // where a cell sits relative to the fill level
    typedef struct packed {
        logic occupied;   // index < occupancy
        logic is_tail;    // index == occupancy - 1
        logic at_end;     // index == occupancy
    } cell_pos_t;

endpackage

// ===== rtl/core/sctl_cell.sv =====
`timescale 1ns / 1ps

module sctl_cell
    import sctl_pkg::*;
(
    input  logic                    clk,
    input  cell_cmd_t               cmd,
    input  cell_pos_t               pos,
    input  logic [ID_W-1:0]         prev_id,
    input  logic signed [KEY_W-1:0] prev_key,
    input  logic [ID_W-1:0]         nxt_id,
    input  logic signed [KEY_W-1:0] nxt_key,
    input  logic [ID_W-1:0]         head_id,
    input  logic signed [KEY_W-1:0] head_key,
    input  logic                    seen_in,
    input  logic                    found_in,
    output logic                    seen_out,
    output logic                    found_out,
    output logic [ID_W-1:0]         id_q,
    output logic signed [KEY_W-1:0] key_q,
    output logic [ID_W-1:0]         id_upd,
    output logic signed [KEY_W-1:0] key_upd
);

    logic [ID_W-1:0]         id_reg;
    logic [ID_W-1:0]         id_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    lower;
    logic                    match;

    assign lower     = pos.occupied && (key_reg < cmd.priority_req);
    assign match     = pos.occupied && (id_reg == cmd.entry_id);
    assign seen_out  = seen_in | lower;
    assign found_out = found_in | match;

    always_comb
    begin
        id_next  = id_reg;
        key_next = key_reg;
        if (cmd.enable)
        begin
            case (cmd.func)
                FUNC_INSERT:
                begin
                    // everything from the insertion point onwards moves back one
                    if (seen_in)
                    begin
                        id_next  = prev_id;
                        key_next = prev_key;
                    end
                    else if (lower || pos.at_end)
                    begin
                        id_next  = cmd.entry_id;
                        key_next = cmd.priority_req;
                    end
                end
                FUNC_REMOVE:
                begin
                    if (found_in || match)
                    begin
                        id_next  = nxt_id;
                        key_next = nxt_key;
                    end
                end
                FUNC_ROTATE:
                begin
                    if (pos.is_tail)
                    begin
                        id_next  = head_id;
                        key_next = head_key;
                    end
                    else if (pos.occupied)
                    begin
                        id_next  = nxt_id;
                        key_next = nxt_key;
                    end
                end
                default:
                begin
                    id_next  = id_reg;
                    key_next = key_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign id_q    = id_reg;
    assign key_q   = key_reg;
    assign id_upd  = id_next;
    assign key_upd = key_next;

endmodule

// ===== rtl/core/sorted_circular_turn_list_unit.sv =====
`timescale 1ns / 1ps
// Sorted circular turn list.
// Input channel in_valid/in_ready/in_data carries one command beat: insert
// (ordered by priority, higher first, equal keys behind), remove by
// identifier, or rotate the head on by one. Output channel
// out_valid/out_ready/out_data returns one beat per command with the head
// entry, empty flag, entry count and a status code.
// The entries live in a row of cells, cell 0 being the head. A command is
// latched on acceptance and applied once the output register is free, when
// every cell compares against it and shifts from its neighbour in one step;
// the result is registered at the same edge. in_ready stays low while the
// latched command waits to be applied, so a new command is not accepted
// until the previous one has been applied.
// While a result waits on out_ready the next command is still accepted and
// held; it is applied once the output register frees up.
// Reset empties the list (count zero) and clears both channels; the cell
// contents are not reset and are never read beyond the count.
module sorted_circular_turn_list_unit
    import sctl_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic            busy_reg;
    logic            busy_next;
    in_item_t        op_reg;
    in_item_t        op_next;
    logic [CW-1:0]   occ_reg;
    logic [CW-1:0]   occ_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    out_item_t       out_reg;
    out_item_t       out_next;

    logic            commit;
    logic            full;
    logic            found;
    cell_cmd_t       cmd;
    logic [1:0]      status;
    logic [31:0]     occ_wide;

    logic                    seen  [0:MAX_ENTRIES];
    logic                    hit   [0:MAX_ENTRIES];
    logic [ID_W-1:0]         id_q  [0:MAX_ENTRIES-1];
    logic signed [KEY_W-1:0] key_q [0:MAX_ENTRIES-1];
    logic [ID_W-1:0]         id_u  [0:MAX_ENTRIES-1];
    logic signed [KEY_W-1:0] key_u [0:MAX_ENTRIES-1];

    assign in_ready = !busy_reg;
    assign commit   = busy_reg && (!out_valid_reg || out_ready);
    assign full     = (occ_reg == CW'(MAX_ENTRIES));
    assign found    = hit[MAX_ENTRIES];

    always_comb
    begin
        cmd.func         = op_reg.func;
        cmd.entry_id     = op_reg.entry_id;
        cmd.priority_req = op_reg.priority_req;
        cmd.enable       = commit && !((op_reg.func == FUNC_INSERT) && full);
    end

    assign seen[0] = 1'b0;
    assign hit[0]  = 1'b0;

    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        cell_pos_t               pos;
        logic [ID_W-1:0]         p_id;
        logic signed [KEY_W-1:0] p_key;
        logic [ID_W-1:0]         n_id;
        logic signed [KEY_W-1:0] n_key;

        assign pos.occupied = (CW'(k) < occ_reg);
        assign pos.is_tail  = (CW'(k + 1) == occ_reg);
        assign pos.at_end   = (CW'(k) == occ_reg);

        if (k == 0)
        begin : g_first
            assign p_id  = '0;
            assign p_key = '0;
        end
        else
        begin : g_mid
            assign p_id  = id_q[k-1];
            assign p_key = key_q[k-1];
        end

        if (k == MAX_ENTRIES - 1)
        begin : g_last
            assign n_id  = id_q[k];
            assign n_key = key_q[k];
        end
        else
        begin : g_inner
            assign n_id  = id_q[k+1];
            assign n_key = key_q[k+1];
        end

        sctl_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .pos       (pos),
            .prev_id   (p_id),
            .prev_key  (p_key),
            .nxt_id    (n_id),
            .nxt_key   (n_key),
            .head_id   (id_q[0]),
            .head_key  (key_q[0]),
            .seen_in   (seen[k]),
            .found_in  (hit[k]),
            .seen_out  (seen[k+1]),
            .found_out (hit[k+1]),
            .id_q      (id_q[k]),
            .key_q     (key_q[k]),
            .id_upd    (id_u[k]),
            .key_upd   (key_u[k])
        );
    end

    always_comb
    begin
        status   = ST_OK;
        occ_next = occ_reg;
        case (op_reg.func)
            FUNC_INSERT:
            begin
                if (full)
                    status = ST_FULL;
                else
                    occ_next = occ_reg + CW'(1);
            end
            FUNC_REMOVE:
            begin
                if (found)
                    occ_next = occ_reg - CW'(1);
                else
                    status = ST_NOT_FOUND;
            end
            FUNC_ROTATE:
            begin
                if (occ_reg == '0)
                    status = ST_EMPTY_ROTATE;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign occ_wide = 32'(occ_next);

    always_comb
    begin
        busy_next      = busy_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (commit)
        begin
            busy_next                = 1'b0;
            out_valid_next           = 1'b1;
            out_next.list_empty      = (occ_next == '0);
            out_next.head_id         = (occ_next == '0) ? '0 : id_u[0];
            out_next.head_priority   = (occ_next == '0) ? '0 : key_u[0];
            out_next.entry_total     = occ_wide[TOTAL_W-1:0];
            out_next.status          = status;
        end

        if (in_valid && in_ready)
        begin
            busy_next = 1'b1;
            op_next   = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (commit)
                occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(MAX_ENTRIES))
        else $error("fill level beyond capacity");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("applied command produced no result beat");

    a_occ_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(occ_reg))
        else $error("fill level changed with no command applied");

    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_valid_reg && !out_ready |=> busy_reg && $stable(op_reg))
        else $error("pending command lost while output stalled");

endmodule
